FILE: sv/muscl3_face_reconstruction_top_macros.svh
// Assertion macros for the MUSCL face reconstruction block.
// Expects clk and rst_n in scope where used.
`ifndef MUSCL3_FACE_RECONSTRUCTION_TOP_MACROS_SVH
`define MUSCL3_FACE_RECONSTRUCTION_TOP_MACROS_SVH

// same-cycle implication
`define MUSCL3_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define MUSCL3_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: sv/muscl3_pkg.sv
// Shared constants for the MUSCL face reconstruction block.
// No dependencies.
package muscl3_pkg;
  localparam int unsigned EPS_W = 32;
  localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;
endpackage

FILE: sv/muscl3_ifs.sv
// Valid/ready channel interfaces: window in, face out, epsilon write.
// Depends on muscl3_pkg.
interface muscl3_in_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] cell_left;
  logic signed [VALUE_WIDTH-1:0] cell_middle;
  logic signed [VALUE_WIDTH-1:0] cell_right;
  logic                          upwind_positive;
  modport source (output valid, cell_left, cell_middle, cell_right, upwind_positive,
                  input ready);
  modport sink (input valid, cell_left, cell_middle, cell_right, upwind_positive,
                output ready);
endinterface

interface muscl3_out_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] face_value;
  logic                          saturated;
  logic                          limiter_defaulted;
  modport source (output valid, face_value, saturated, limiter_defaulted, input ready);
  modport sink (input valid, face_value, saturated, limiter_defaulted, output ready);
endinterface

interface muscl3_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [muscl3_pkg::EPS_W-1:0]       limiter_epsilon;
  modport source (output valid, limiter_epsilon, input ready);
  modport sink (input valid, limiter_epsilon, output ready);
endinterface

FILE: sv/muscl3_div_cell.sv
// One restoring-division step: shift remainder, subtract divisor, emit a quotient bit.
// Carries a side word along unchanged. No package dependency.
module muscl3_div_cell #(
  parameter int W      = 72,
  parameter int PB     = 32,
  parameter int PASS_W = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [W-1:0]      in_rem,
  input  logic [W-1:0]      in_den,
  input  logic [PB-1:0]     in_phi,
  input  logic [PASS_W-1:0] in_pass,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [W-1:0]      out_rem,
  output logic [W-1:0]      out_den,
  output logic [PB-1:0]     out_phi,
  output logic [PASS_W-1:0] out_pass
);
  logic              v_r;
  logic [W-1:0]      rem_r, den_r;
  logic [PB-1:0]     phi_r;
  logic [PASS_W-1:0] pass_r;
  logic [W:0]        shifted;
  logic              take;
  logic [W-1:0]      rem_nxt;

  assign in_ready = !v_r || out_ready;
  assign shifted  = {in_rem, 1'b0};
  assign take     = shifted >= {1'b0, in_den};

  always_comb begin
    rem_nxt = shifted[W-1:0];
    if (take) begin
      rem_nxt = W'(shifted - {1'b0, in_den});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      den_r  <= in_den;
      phi_r  <= {in_phi[PB-2:0], take};
      pass_r <= in_pass;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_phi   = phi_r;
  assign out_pass  = pass_r;
endmodule

FILE: sv/muscl3_face_reconstruction_top.sv
// Limited third-order MUSCL face reconstruction: one window of three cells in,
// one limited face value out per word, at one word per clock while the output is
// not stalled. Four front stages form the differences, products and limiter
// numerator/denominator, a chain of 2*FRACTION_BITS division cells produces the
// limiter one bit per cell, and three back stages scale, divide by six and
// saturate. Every stage holds its word under backpressure and empty stages fill,
// so input is taken while a result waits.
// Depends on muscl3_pkg, muscl3_ifs, muscl3_div_cell and the macros header.
`include "muscl3_face_reconstruction_top_macros.svh"
module muscl3_face_reconstruction_top #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  muscl3_in_if.sink    in_word,
  muscl3_out_if.source out_word,
  muscl3_cfg_if.sink   cfg_word
);
  localparam int V  = VALUE_WIDTH;
  localparam int PB = 2 * FRACTION_BITS;
  localparam int DW = V + 1;
  localparam int EW = V + 2;
  localparam int SW = V + 3;
  localparam int PW = 2 * DW;
  localparam int QW = 2 * EW;
  localparam int W  = 2 * V + 8;
  localparam int N  = V + 2;
  localparam int K  = N + 1;
  localparam int FW = V + 3;
  localparam logic [K-1:0] RECIP = K'(((64'd1 << K) - 64'd1) / 64'd3);

  typedef struct packed {
    logic [V-1:0]  near;
    logic          sneg;
    logic [SW-1:0] smag;
    logic          nneg;
    logic          dflt;
    logic          sat;
    logic          skip;
  } pass_t;
  localparam int PASS_W = $bits(pass_t);

  // epsilon register
  logic [muscl3_pkg::EPS_W-1:0] eps_r;
  assign cfg_word.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= muscl3_pkg::EPS_RESET;
    end else if (cfg_word.valid) begin
      eps_r <= cfg_word.limiter_epsilon;
    end
  end

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_m, rdy_g, rdy_f;
  logic va_r, vb_r, vc_r, vd_r, vm_r, vg_r, vf_r;
  logic rdy_cell [0:PB];

  // stage A: order the window, differences
  logic [V-1:0]  far_in, cen_in;
  logic [DW-1:0] d1_a_r, d2_a_r;
  logic [V-1:0]  near_a_r;
  assign far_in = in_word.upwind_positive ? in_word.cell_left : in_word.cell_right;
  assign cen_in = in_word.upwind_positive ? in_word.cell_right : in_word.cell_left;
  assign rdy_a = !va_r || rdy_b;
  assign in_word.ready = rdy_a;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_word.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy_a && in_word.valid) begin
      d1_a_r   <= {in_word.cell_middle[V-1], in_word.cell_middle} - {far_in[V-1], far_in};
      d2_a_r   <= {cen_in[V-1], cen_in} - {in_word.cell_middle[V-1], in_word.cell_middle};
      near_a_r <= in_word.cell_middle;
    end
  end

  // stage B: magnitudes, cross product
  logic [EW-1:0] e_b;
  logic [SW-1:0] s_b;
  logic [DW-1:0] m1_b, m2_b;
  logic [PW-1:0] pm_b_r;
  logic [EW-1:0] emag_b_r;
  logic [SW-1:0] smag_b_r;
  logic          sneg_b_r, pneg_b_r;
  logic [V-1:0]  near_b_r;
  assign e_b  = {d2_a_r[DW-1], d2_a_r} - {d1_a_r[DW-1], d1_a_r};
  assign s_b  = {d2_a_r[DW-1], d2_a_r, 1'b0} + {{2{d1_a_r[DW-1]}}, d1_a_r};
  assign m1_b = d1_a_r[DW-1] ? DW'(-d1_a_r) : d1_a_r;
  assign m2_b = d2_a_r[DW-1] ? DW'(-d2_a_r) : d2_a_r;
  assign rdy_b = !vb_r || rdy_c;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      pm_b_r   <= PW'(m1_b * m2_b);
      emag_b_r <= e_b[EW-1] ? EW'(-e_b) : e_b;
      smag_b_r <= s_b[SW-1] ? SW'(-s_b) : s_b;
      sneg_b_r <= s_b[SW-1];
      pneg_b_r <= (d1_a_r[DW-1] != d2_a_r[DW-1]) && (d1_a_r != '0) && (d2_a_r != '0);
      near_b_r <= near_a_r;
    end
  end

  // stage C: square, triple
  logic [QW-1:0]   q_c_r;
  logic [PW+1:0]   t3_c_r;
  logic [SW-1:0]   smag_c_r;
  logic            sneg_c_r, pneg_c_r;
  logic [V-1:0]    near_c_r;
  assign rdy_c = !vc_r || rdy_d;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= vb_r;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      q_c_r    <= QW'(emag_b_r * emag_b_r);
      t3_c_r   <= {1'b0, pm_b_r, 1'b0} + {2'b0, pm_b_r};
      smag_c_r <= smag_b_r;
      sneg_c_r <= sneg_b_r;
      pneg_c_r <= pneg_b_r;
      near_c_r <= near_b_r;
    end
  end

  // stage D: limiter numerator and denominator
  logic [W-1:0] base_d, t3_d, eps_d, num_d, den_d;
  logic         nneg_d;
  logic [W-1:0] num_d_r, den_d_r;
  logic         nneg_d_r, sneg_d_r;
  logic [SW-1:0] smag_d_r;
  logic [V-1:0] near_d_r;
  assign t3_d   = W'(t3_c_r);
  assign eps_d  = W'(eps_r);
  assign base_d = {W'(q_c_r)} + {W'(q_c_r)} + eps_d;
  always_comb begin
    nneg_d = 1'b0;
    if (!pneg_c_r) begin
      num_d = t3_d + eps_d;
      den_d = base_d + t3_d;
    end else begin
      if (eps_d >= t3_d) begin
        num_d = eps_d - t3_d;
      end else begin
        num_d  = t3_d - eps_d;
        nneg_d = 1'b1;
      end
      den_d = (base_d >= t3_d) ? base_d - t3_d : '0;
    end
  end
  assign rdy_d = !vd_r || rdy_cell[0];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (rdy_d) begin
      vd_r <= vc_r;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy_d && vc_r) begin
      num_d_r  <= num_d;
      den_d_r  <= den_d;
      nneg_d_r <= nneg_d;
      sneg_d_r <= sneg_c_r;
      smag_d_r <= smag_c_r;
      near_d_r <= near_c_r;
    end
  end

  // division chain
  logic              v_cell   [0:PB];
  logic [W-1:0]      rem_cell [0:PB];
  logic [W-1:0]      den_cell [0:PB];
  logic [PB-1:0]     phi_cell [0:PB];
  logic [PASS_W-1:0] pass_cell[0:PB];
  pass_t             pass_in, pass_out;
  logic              skip_in;

  assign skip_in          = (den_d_r == '0) || (num_d_r >= den_d_r);
  assign pass_in.near     = near_d_r;
  assign pass_in.sneg     = sneg_d_r;
  assign pass_in.smag     = smag_d_r;
  assign pass_in.nneg     = nneg_d_r;
  assign pass_in.dflt     = den_d_r == '0;
  assign pass_in.sat      = (den_d_r != '0) && (num_d_r > den_d_r);
  assign pass_in.skip     = skip_in;
  assign v_cell[0]        = vd_r;
  assign rem_cell[0]      = skip_in ? '0 : num_d_r;
  assign den_cell[0]      = skip_in ? W'(1) : den_d_r;
  assign phi_cell[0]      = '0;
  assign pass_cell[0]     = pass_in;
  assign rdy_cell[PB]     = rdy_m;

  for (genvar i = 0; i < PB; i++) begin : g_cell
    muscl3_div_cell #(.W(W), .PB(PB), .PASS_W(PASS_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v_cell[i]),
      .in_ready (rdy_cell[i]),
      .in_rem   (rem_cell[i]),
      .in_den   (den_cell[i]),
      .in_phi   (phi_cell[i]),
      .in_pass  (pass_cell[i]),
      .out_valid(v_cell[i+1]),
      .out_ready(rdy_cell[i+1]),
      .out_rem  (rem_cell[i+1]),
      .out_den  (den_cell[i+1]),
      .out_phi  (phi_cell[i+1]),
      .out_pass (pass_cell[i+1])
    );
  end

  // stage M: scale by limiter
  logic [PB:0]      phi_m;
  logic [PB+SW:0]   prod_m;
  logic [SW-1:0]    x_m_r;
  logic             neg_m_r, sat_m_r, dflt_m_r;
  logic [V-1:0]     near_m_r;
  assign pass_out = pass_cell[PB];
  assign phi_m    = pass_out.skip ? {1'b1, PB'(0)} : {1'b0, phi_cell[PB]};
  assign prod_m   = (PB+SW+1)'(phi_m * pass_out.smag);
  assign rdy_m    = !vm_r || rdy_g;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (rdy_m) begin
      vm_r <= v_cell[PB];
    end
  end
  always_ff @(posedge clk) begin
    if (rdy_m && v_cell[PB]) begin
      x_m_r    <= prod_m[PB +: SW];
      neg_m_r  <= (pass_out.nneg && !pass_out.dflt) != pass_out.sneg;
      sat_m_r  <= pass_out.sat;
      dflt_m_r <= pass_out.dflt;
      near_m_r <= pass_out.near;
    end
  end

  // stage G: divide by six, reciprocal estimate
  logic [N-1:0]   y_g;
  logic [N+K-1:0] rp_g;
  logic [N-1:0]   y_g_r, q0_g_r;
  logic           neg_g_r, sat_g_r, dflt_g_r;
  logic [V-1:0]   near_g_r;
  assign y_g  = x_m_r[SW-1:1];
  assign rp_g = (N+K)'(y_g * RECIP);
  assign rdy_g = !vg_r || rdy_f;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
    end else if (rdy_g) begin
      vg_r <= vm_r;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy_g && vm_r) begin
      y_g_r    <= y_g;
      q0_g_r   <= rp_g[K +: N];
      neg_g_r  <= neg_m_r;
      sat_g_r  <= sat_m_r;
      dflt_g_r <= dflt_m_r;
      near_g_r <= near_m_r;
    end
  end

  // stage F: correct quotient, apply, saturate
  logic [N+1:0]  r_f;
  logic [N-1:0]  adj_f;
  logic [FW-1:0] face_f;
  logic          ovf_f;
  logic [V-1:0]  clip_f;
  logic [V-1:0]  face_f_r;
  logic          sat_f_r, dflt_f_r;
  assign r_f    = {2'b0, y_g_r} - ({1'b0, q0_g_r, 1'b0} + {2'b0, q0_g_r});
  assign adj_f  = q0_g_r + N'(r_f >= (N+2)'(3));
  assign face_f = neg_g_r ? {{3{near_g_r[V-1]}}, near_g_r} - {1'b0, adj_f}
                          : {{3{near_g_r[V-1]}}, near_g_r} + {1'b0, adj_f};
  assign ovf_f  = !((face_f[FW-1:V-1] == '0) || (face_f[FW-1:V-1] == '1));
  assign clip_f = face_f[FW-1] ? {1'b1, (V-1)'(0)} : {1'b0, {(V-1){1'b1}}};
  assign rdy_f  = !vf_r || out_word.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (rdy_f) begin
      vf_r <= vg_r;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy_f && vg_r) begin
      face_f_r <= ovf_f ? clip_f : face_f[V-1:0];
      sat_f_r  <= sat_g_r || ovf_f;
      dflt_f_r <= dflt_g_r;
    end
  end

  assign out_word.valid             = vf_r;
  assign out_word.face_value        = face_f_r;
  assign out_word.saturated         = sat_f_r;
  assign out_word.limiter_defaulted = dflt_f_r;

  `MUSCL3_ASSERT_NOW(a_stall_full, !in_word.ready, va_r && vf_r, "input stalled with room in pipe")
  `MUSCL3_ASSERT_NEXT(a_eps_write, cfg_word.valid && cfg_word.ready, eps_r == $past(cfg_word.limiter_epsilon), "epsilon write lost")
  `MUSCL3_ASSERT_NOW(a_dflt_skip, vd_r && den_d_r == '0, skip_in, "zero denominator not bypassed")
endmodule
